// ----- sv/rmrs_pkg.sv -----
// Shared types, widths and constants for the running mean and Reynolds stress block.
package rmrs_pkg;

    localparam int W = 48;
    localparam int CELL_W = 12;
    localparam int COUNT_W = 32;
    localparam int M_W = COUNT_W + 1;
    localparam int NUM_MEANS = 5;
    localparam int NUM_PRODUCTS = 6;

    // Dividend of the rounded division is 2*|d| + m, at most 50 bits wide.
    localparam int DIV_BITS = 50;
    localparam int LANE_LAT = DIV_BITS + 3;
    localparam int PRE_LAT = 3;
    localparam int MERGE_LAT = 2;

    localparam int IN_TDATA_W = 256;
    localparam int OUT_TDATA_W = 544;

    localparam int NUM_CELLS_DEF = 4096;
    localparam int NUM_COMPONENTS_DEF = 5;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic CFG_AVG_ON = 1'b0;
    localparam logic CFG_DIM = 1'b1;

    typedef logic signed [W-1:0] t_w48;

    typedef struct packed {
        logic              upd;
        logic [CELL_W-1:0] cidx;
        logic [M_W-1:0]    m;
    } t_lane_in;

    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] cidx;
    } t_clr;

endpackage

// ----- sv/rmrs_fmul.sv -----
// Two-stage signed fixed-point multiplier with rounding and 48-bit saturation.
module rmrs_fmul #(
    parameter int FRAC_BITS = rmrs_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  rmrs_pkg::t_w48 i_a,
    input  rmrs_pkg::t_w48 i_b,
    output rmrs_pkg::t_w48 o_y
);
    import rmrs_pkg::*;

    logic [W-1:0]   ma, mb;
    logic [W-1:0]   r_p00, r_p01, r_p10, r_p11;
    logic           r_neg;
    logic [2*W-1:0] prod;
    logic [2*W:0]   rsum, rs;
    logic           sat;
    logic [W-1:0]   y;
    t_w48           r_y;

    assign ma = i_a[W-1] ? (W'(0) - W'(i_a)) : W'(i_a);
    assign mb = i_b[W-1] ? (W'(0) - W'(i_b)) : W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= ma[23:0] * mb[23:0];
            r_p01 <= ma[23:0] * mb[47:24];
            r_p10 <= ma[47:24] * mb[23:0];
            r_p11 <= ma[47:24] * mb[47:24];
            r_neg <= i_a[W-1] ^ i_b[W-1];
        end
    end

    always_comb begin
        prod = {48'd0, r_p00} + ({48'd0, r_p01} << 24) + ({48'd0, r_p10} << 24)
             + {r_p11, 48'd0};
        rsum = {1'b0, prod} + ((2*W+1)'(1) << (FRAC_BITS - 1));
        rs   = rsum >> FRAC_BITS;
        sat  = rs >= ((2*W+1)'(1) << (W - 1));
        if (r_neg) begin
            y = sat ? {1'b1, {(W-1){1'b0}}} : (W'(0) - rs[W-1:0]);
        end else begin
            y = sat ? {1'b0, {(W-1){1'b1}}} : rs[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= t_w48'(y);
        end
    end

    assign o_y = r_y;

endmodule

// ----- sv/rmrs_lane.sv -----
// One averaging lane: per-cell store and a pipelined rounded cumulative-mean update.
module rmrs_lane #(
    parameter int DEPTH = rmrs_pkg::NUM_CELLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  rmrs_pkg::t_lane_in i_in,
    input  rmrs_pkg::t_w48     i_x,
    input  rmrs_pkg::t_clr     i_clr,
    output rmrs_pkg::t_w48     o_res
);
    import rmrs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NB = DIV_BITS;

    logic [W-1:0] r_mem [DEPTH];

    // Read stage.
    logic           r_rd_upd;
    t_w48           r_rd_mean, r_rd_x;
    logic [M_W-1:0] r_rd_m;
    logic [AW-1:0]  r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_upd <= 1'b0;
        end else if (i_adv) begin
            r_rd_upd <= i_in.upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd_mean <= t_w48'(r_mem[i_in.cidx[AW-1:0]]);
            r_rd_x    <= i_x;
            r_rd_m    <= i_in.m;
            r_rd_addr <= i_in.cidx[AW-1:0];
        end
    end

    // Difference and dividend 2*|x-mean| + m over divisor 2*m.
    logic signed [W:0] d;
    logic [W:0]        da;
    logic [NB-1:0]     nd;

    assign d  = {r_rd_x[W-1], r_rd_x} - {r_rd_mean[W-1], r_rd_mean};
    assign da = d[W] ? ((W+1)'(0) - (W+1)'(d)) : (W+1)'(d);
    assign nd = {1'b0, da[W-1:0], 1'b0} + {{(NB-M_W){1'b0}}, r_rd_m};

    logic [NB-1:0] r_n    [NB+1];
    logic [M_W:0]  r_den  [NB+1];
    logic [M_W:0]  r_rem  [NB+1];
    logic [W-1:0]  r_q    [NB+1];
    logic          r_neg  [NB+1];
    t_w48          r_mean [NB+1];
    logic [AW-1:0] r_addr [NB+1];
    logic          r_upd  [NB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd[0] <= 1'b0;
        end else if (i_adv) begin
            r_upd[0] <= r_rd_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_n[0]    <= nd;
            r_den[0]  <= {r_rd_m, 1'b0};
            r_rem[0]  <= '0;
            r_q[0]    <= '0;
            r_neg[0]  <= d[W];
            r_mean[0] <= r_rd_mean;
            r_addr[0] <= r_rd_addr;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 1; k <= NB; k++) begin : g_div
        logic [M_W+1:0] t, dif;
        logic           ge;

        assign t   = {r_rem[k-1], r_n[k-1][NB-k]};
        assign dif = t - {1'b0, r_den[k-1]};
        assign ge  = t >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_upd[k] <= 1'b0;
            end else if (i_adv) begin
                r_upd[k] <= r_upd[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_n[k]    <= r_n[k-1];
                r_den[k]  <= r_den[k-1];
                r_rem[k]  <= ge ? dif[M_W:0] : t[M_W:0];
                r_q[k]    <= {r_q[k-1][W-2:0], ge};
                r_neg[k]  <= r_neg[k-1];
                r_mean[k] <= r_mean[k-1];
                r_addr[k] <= r_addr[k-1];
            end
        end
    end

    logic [W-1:0] res;
    t_w48         r_res;

    assign res = r_neg[NB] ? (W'(r_mean[NB]) - r_q[NB]) : (W'(r_mean[NB]) + r_q[NB]);

    always_ff @(posedge i_clk) begin
        if (i_clr.en) begin
            r_mem[i_clr.cidx[AW-1:0]] <= '0;
        end else if (i_adv && r_upd[NB]) begin
            r_mem[r_addr[NB]] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= t_w48'(res);
        end
    end

    assign o_res = r_res;

endmodule

// ----- sv/rmrs_merge.sv -----
// Merging stage: products of the new means, fluctuations and masking by dimension.
module rmrs_merge #(
    parameter int FRAC_BITS = rmrs_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_adv,
    input  logic [1:0]     i_edim,
    input  rmrs_pkg::t_w48 i_mean  [rmrs_pkg::NUM_MEANS],
    input  rmrs_pkg::t_w48 i_prod  [rmrs_pkg::NUM_PRODUCTS],
    output rmrs_pkg::t_w48 o_mean  [rmrs_pkg::NUM_MEANS],
    output rmrs_pkg::t_w48 o_fluct [rmrs_pkg::NUM_PRODUCTS]
);
    import rmrs_pkg::*;

    t_w48 op_a [NUM_PRODUCTS];
    t_w48 op_b [NUM_PRODUCTS];
    t_w48 mm   [NUM_PRODUCTS];
    t_w48 r_mean1 [NUM_MEANS];
    t_w48 r_mean2 [NUM_MEANS];
    t_w48 r_prod1 [NUM_PRODUCTS];
    t_w48 r_prod2 [NUM_PRODUCTS];
    logic used [NUM_PRODUCTS];

    // Mean order is 0, u, v, w, last.
    assign op_a[0] = i_mean[1];
    assign op_b[0] = i_mean[1];
    assign op_a[1] = i_mean[2];
    assign op_b[1] = i_mean[2];
    assign op_a[2] = (i_edim == 2'd3) ? i_mean[3] : i_mean[1];
    assign op_b[2] = (i_edim == 2'd3) ? i_mean[3] : i_mean[2];
    assign op_a[3] = i_mean[1];
    assign op_b[3] = i_mean[2];
    assign op_a[4] = i_mean[1];
    assign op_b[4] = i_mean[3];
    assign op_a[5] = i_mean[2];
    assign op_b[5] = i_mean[3];

    assign used[0] = 1'b1;
    assign used[1] = i_edim >= 2'd2;
    assign used[2] = i_edim >= 2'd2;
    assign used[3] = i_edim == 2'd3;
    assign used[4] = i_edim == 2'd3;
    assign used[5] = i_edim == 2'd3;

    for (genvar k = 0; k < NUM_PRODUCTS; k++) begin : g_mul
        logic signed [W:0] diff;

        rmrs_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
            .i_clk (i_clk),
            .i_en  (i_adv),
            .i_a   (op_a[k]),
            .i_b   (op_b[k]),
            .o_y   (mm[k])
        );

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_prod1[k] <= i_prod[k];
                r_prod2[k] <= r_prod1[k];
            end
        end

        assign diff = {r_prod2[k][W-1], r_prod2[k]} - {mm[k][W-1], mm[k]};

        always_comb begin
            if (!used[k]) begin
                o_fluct[k] = '0;
            end else if (diff[W] != diff[W-1]) begin
                o_fluct[k] = diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                o_fluct[k] = diff[W-1:0];
            end
        end
    end

    for (genvar k = 0; k < NUM_MEANS; k++) begin : g_mean
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_mean1[k] <= i_mean[k];
                r_mean2[k] <= r_mean1[k];
            end
        end
        assign o_mean[k] = r_mean2[k];
    end

endmodule

// ----- sv/running_mean_reynolds_stress.sv -----
// Top level of the per-cell running mean and Reynolds stress block.
// One item per cycle is taken while the output side accepts, no cell hazard stands and the
// reset sweep is done. An item whose cell is still in flight waits until the earlier item of
// that cell has reached the output register.
// The 50-stage division pipeline in each lane sets the latency; the lanes run in lockstep.
// Reset (synchronous, active low) clears control state and then sweeps the first
// min(NUM_CELLS, 4096) cells of the stores to zero, one cell per cycle, before the first transfer.
module running_mean_reynolds_stress #(
    parameter int NUM_CELLS      = rmrs_pkg::NUM_CELLS_DEF,
    parameter int NUM_COMPONENTS = rmrs_pkg::NUM_COMPONENTS_DEF,
    parameter int FRAC_BITS      = rmrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input item.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // From bit 0: cell_index, prim_0, prim_u, prim_v, prim_w, prim_last, zero pad.
    input  logic [rmrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // last_cell.
    input  logic                                s_axis_tlast,
    // Result item.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // From bit 0: out_cell, mean_0, mean_u, mean_v, mean_w, mean_last, fluct_uu,
    // fluct_vv, fluct_ww_or_uv, fluct_uv_3d, fluct_uw, fluct_vw, zero pad.
    output logic [rmrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration writes.
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_addr,
    input  logic [1:0]                          i_cfg_wdata
);
    import rmrs_pkg::*;

    localparam int CELL_LIMIT = 1 << CELL_W;
    localparam int DEPTH = (NUM_CELLS < CELL_LIMIT) ? NUM_CELLS : CELL_LIMIT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int T = PRE_LAT + LANE_LAT + MERGE_LAT;

    // Configuration and the step counter.
    logic               r_avg_on;
    logic [1:0]         r_dim;
    logic [COUNT_W-1:0] r_count;
    logic [1:0]         edim;

    always_comb begin
        edim = (r_dim == 2'd0) ? 2'd1 : r_dim;
        if (edim > 2'(NUM_COMPONENTS - 2)) begin
            edim = 2'(NUM_COMPONENTS - 2);
        end
    end

    // Input fields.
    logic [CELL_W-1:0] in_cell;
    t_w48              in_prim [NUM_MEANS];

    assign in_cell = s_axis_tdata[CELL_W-1:0];
    for (genvar k = 0; k < NUM_MEANS; k++) begin : g_in
        assign in_prim[k] = t_w48'(s_axis_tdata[CELL_W + k*W +: W]);
    end

    // The whole pipeline moves when the output register is free or being emptied.
    logic r_out_valid;
    logic adv;
    logic hazard;
    logic r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic acc, in_range, take;

    logic              r_tag_v    [T];
    logic [CELL_W-1:0] r_tag_cell [T];

    assign adv = !r_out_valid || m_axis_tready;

    // A cell may not be read while an earlier update of it has not been written back.
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < T; k++) begin
            hazard = hazard | (r_tag_v[k] && (r_tag_cell[k] == in_cell));
        end
    end

    assign s_axis_tready = adv && !hazard && !r_clearing;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign in_range = 32'(in_cell) < 32'(NUM_CELLS);
    assign take     = acc && r_avg_on && in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_on <= 1'b1;
            r_dim    <= 2'd3;
            r_count  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_AVG_ON: begin
                    r_avg_on <= i_cfg_wdata[0];
                    if (!i_cfg_wdata[0]) begin
                        r_count <= '0;
                    end
                end
                CFG_DIM: r_dim <= i_cfg_wdata;
                default: r_dim <= r_dim;
            endcase
        end else if (acc && !r_avg_on) begin
            r_count <= '0;
        end else if (take && s_axis_tlast && (r_count != '1)) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Clearing sweep of the cell stores after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    t_clr clr;
    assign clr.en   = r_clearing;
    assign clr.cidx = CELL_W'(r_clr_addr);

    // Tag pipeline: one valid bit and cell per stage, all stages in lockstep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < T; k++) begin
                r_tag_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_tag_v[0] <= take;
            for (int k = 1; k < T; k++) begin
                r_tag_v[k] <= r_tag_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tag_cell[0] <= in_cell;
            for (int k = 1; k < T; k++) begin
                r_tag_cell[k] <= r_tag_cell[k-1];
            end
        end
    end

    // Front stages: capture the item with unused velocities zeroed, then form the
    // velocity products over the two multiplier stages.
    t_w48           r_a_prim [NUM_MEANS];
    t_w48           r_p_prim [NUM_MEANS];
    t_w48           r_x_prim [NUM_MEANS];
    logic [M_W-1:0] r_a_m, r_p_m, r_x_m;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_prim[0] <= in_prim[0];
            r_a_prim[1] <= in_prim[1];
            r_a_prim[2] <= (edim >= 2'd2) ? in_prim[2] : '0;
            r_a_prim[3] <= (edim == 2'd3) ? in_prim[3] : '0;
            r_a_prim[4] <= in_prim[4];
            r_a_m       <= {1'b0, r_count} + 1'b1;
            r_p_prim    <= r_a_prim;
            r_x_prim    <= r_p_prim;
            r_p_m       <= r_a_m;
            r_x_m       <= r_p_m;
        end
    end

    t_w48 pa [NUM_PRODUCTS];
    t_w48 pb [NUM_PRODUCTS];
    t_w48 px [NUM_PRODUCTS];
    logic pused [NUM_PRODUCTS];

    assign pa[0] = r_a_prim[1];
    assign pb[0] = r_a_prim[1];
    assign pa[1] = r_a_prim[2];
    assign pb[1] = r_a_prim[2];
    assign pa[2] = (edim == 2'd3) ? r_a_prim[3] : r_a_prim[1];
    assign pb[2] = (edim == 2'd3) ? r_a_prim[3] : r_a_prim[2];
    assign pa[3] = r_a_prim[1];
    assign pb[3] = r_a_prim[2];
    assign pa[4] = r_a_prim[1];
    assign pb[4] = r_a_prim[3];
    assign pa[5] = r_a_prim[2];
    assign pb[5] = r_a_prim[3];

    // Product slots: uu, vv, ww, uv, uw, vw in 3D; uu, vv, uv in 2D; uu alone in 1D.
    assign pused[0] = 1'b1;
    assign pused[1] = edim >= 2'd2;
    assign pused[2] = edim >= 2'd2;
    assign pused[3] = edim == 2'd3;
    assign pused[4] = edim == 2'd3;
    assign pused[5] = edim == 2'd3;

    t_w48 lane_mean [NUM_MEANS];
    t_w48 lane_prod [NUM_PRODUCTS];

    for (genvar k = 0; k < NUM_PRODUCTS; k++) begin : g_plane
        t_lane_in lin;

        rmrs_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (pa[k]),
            .i_b   (pb[k]),
            .o_y   (px[k])
        );

        assign lin.upd  = r_tag_v[PRE_LAT-1] && pused[k];
        assign lin.cidx = r_tag_cell[PRE_LAT-1];
        assign lin.m    = r_x_m;

        rmrs_lane #(.DEPTH(DEPTH)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_in    (lin),
            .i_x     (px[k]),
            .i_clr   (clr),
            .o_res   (lane_prod[k])
        );
    end

    // Mean lanes; the v and w slots exist only when the component count has them.
    for (genvar k = 0; k < NUM_MEANS; k++) begin : g_mlane
        if ((k == 2 && NUM_COMPONENTS < 4) || (k == 3 && NUM_COMPONENTS < 5)) begin : g_none
            assign lane_mean[k] = '0;
        end else begin : g_lane
            t_lane_in lin;

            assign lin.upd  = r_tag_v[PRE_LAT-1];
            assign lin.cidx = r_tag_cell[PRE_LAT-1];
            assign lin.m    = r_x_m;

            rmrs_lane #(.DEPTH(DEPTH)) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_in    (lin),
                .i_x     (r_x_prim[k]),
                .i_clr   (clr),
                .o_res   (lane_mean[k])
            );
        end
    end

    t_w48 mg_mean  [NUM_MEANS];
    t_w48 mg_fluct [NUM_PRODUCTS];

    rmrs_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_edim  (edim),
        .i_mean  (lane_mean),
        .i_prod  (lane_prod),
        .o_mean  (mg_mean),
        .o_fluct (mg_fluct)
    );

    // Output register; it holds a finished result and stalls the pipeline behind it until
    // the downstream side takes the transfer.
    logic [CELL_W-1:0] r_out_cell;
    t_w48              r_out_mean  [NUM_MEANS];
    t_w48              r_out_fluct [NUM_PRODUCTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_tag_v[T-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_cell  <= r_tag_cell[T-1];
            r_out_mean  <= mg_mean;
            r_out_fluct <= mg_fluct;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[CELL_W-1:0] = r_out_cell;
        for (int k = 0; k < NUM_MEANS; k++) begin
            m_axis_tdata[CELL_W + k*W +: W] = r_out_mean[k];
        end
        for (int k = 0; k < NUM_PRODUCTS; k++) begin
            m_axis_tdata[CELL_W + (NUM_MEANS + k)*W +: W] = r_out_fluct[k];
        end
    end

endmodule

// ----- bench/running_mean_reynolds_stress_tb.sv -----
// Self-checking testbench for the running mean and Reynolds stress block.
module running_mean_reynolds_stress_tb;
    import rmrs_pkg::*;

    localparam int NCELLS = 4096;
    localparam int FB = 16;
    localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MIN48 = -64'sh0000_8000_0000_0000;
    // Output latency plus margin, used before configuration writes and at the end.
    localparam int DRAIN_CYCLES = 80;
    // Length of the long receiver stall.
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [11:0] cidx;
        logic        last;
        logic [47:0] p0;
        logic [47:0] pu;
        logic [47:0] pv;
        logic [47:0] pw;
        logic [47:0] pl;
    } t_cell_state;

    // Declared from the top bit down, so the cell index lands in the lowest bits.
    typedef struct packed {
        logic [47:0] f5, f4, f3, f2, f1, f0;
        logic [47:0] ml, mw, mv, mu, m0;
        logic [11:0] cidx;
    } t_cell_avg;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_addr = CFG_AVG_ON;
    logic [1:0] i_cfg_wdata = '0;

    running_mean_reynolds_stress uut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state.
    longint mean_mem [NCELLS][5];
    longint prod_mem [NCELLS][6];
    longint unsigned step_n;
    bit avg_on;
    logic [1:0] dim_reg;

    t_cell_state pending_cells[$];
    t_cell_avg expected_avgs[$];
    int errors = 0;
    bit quiet_tail = 0;    // no idling on either side
    bit hold_sink = 0;     // request for the long receiver stall
    int hold_cnt = 0;      // cycles of the long stall so far
    bit in_acc = 0;        // input transfer taken at the last rising edge
    int sent = 0;

    function automatic longint sx(logic [47:0] x);
        return longint'(signed'(x));
    endfunction

    function automatic longint unsigned absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat(longint v);
        if (v > MAX48) return MAX48;
        if (v < MIN48) return MIN48;
        return v;
    endfunction

    // Mean plus rounded (x - mean)/m, ties away from zero.
    function automatic longint running_avg(longint avg, longint x, longint unsigned m);
        longint d;
        longint unsigned q;
        d = x - avg;
        q = (2 * absval(d) + m) / (2 * m);
        return d < 0 ? avg - longint'(q) : avg + longint'(q);
    endfunction

    // Q-format product, rounded and saturated to 48 bits.
    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        logic [127:0] r;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(absval(a)) * 128'(absval(b)) + (128'd1 << (FB - 1));
        r = p >> FB;
        if (r > 128'h8000_0000_0000) r = 128'h8000_0000_0000;
        if (neg) return -longint'(r[63:0]);
        if (r > 128'h7FFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF;
        return longint'(r[63:0]);
    endfunction

    function automatic longint fluct(longint prod, longint a, longint b);
        return sat(prod - qmul(a, b));
    endfunction

    task automatic predict_cell(t_cell_state it);
        longint unsigned m;
        int c;
        int edim;
        longint u, v, w;
        longint f[6];
        t_cell_avg r;
        if (!avg_on) begin
            step_n = 0;
            return;
        end
        m = step_n + 1;
        c = int'(it.cidx);
        edim = (dim_reg == 0) ? 1 : int'(dim_reg);
        u = sx(it.pu);
        v = edim >= 2 ? sx(it.pv) : 0;
        w = edim >= 3 ? sx(it.pw) : 0;
        mean_mem[c][0] = running_avg(mean_mem[c][0], sx(it.p0), m);
        mean_mem[c][1] = running_avg(mean_mem[c][1], u, m);
        mean_mem[c][2] = running_avg(mean_mem[c][2], v, m);
        mean_mem[c][3] = running_avg(mean_mem[c][3], w, m);
        mean_mem[c][4] = running_avg(mean_mem[c][4], sx(it.pl), m);
        foreach (f[k]) f[k] = 0;
        prod_mem[c][0] = running_avg(prod_mem[c][0], qmul(u, u), m);
        f[0] = fluct(prod_mem[c][0], mean_mem[c][1], mean_mem[c][1]);
        if (edim == 2) begin
            prod_mem[c][1] = running_avg(prod_mem[c][1], qmul(v, v), m);
            prod_mem[c][2] = running_avg(prod_mem[c][2], qmul(u, v), m);
            f[1] = fluct(prod_mem[c][1], mean_mem[c][2], mean_mem[c][2]);
            f[2] = fluct(prod_mem[c][2], mean_mem[c][1], mean_mem[c][2]);
        end else if (edim == 3) begin
            prod_mem[c][1] = running_avg(prod_mem[c][1], qmul(v, v), m);
            prod_mem[c][2] = running_avg(prod_mem[c][2], qmul(w, w), m);
            prod_mem[c][3] = running_avg(prod_mem[c][3], qmul(u, v), m);
            prod_mem[c][4] = running_avg(prod_mem[c][4], qmul(u, w), m);
            prod_mem[c][5] = running_avg(prod_mem[c][5], qmul(v, w), m);
            f[1] = fluct(prod_mem[c][1], mean_mem[c][2], mean_mem[c][2]);
            f[2] = fluct(prod_mem[c][2], mean_mem[c][3], mean_mem[c][3]);
            f[3] = fluct(prod_mem[c][3], mean_mem[c][1], mean_mem[c][2]);
            f[4] = fluct(prod_mem[c][4], mean_mem[c][1], mean_mem[c][3]);
            f[5] = fluct(prod_mem[c][5], mean_mem[c][2], mean_mem[c][3]);
        end
        r.cidx = it.cidx;
        r.m0 = mean_mem[c][0][47:0];
        r.mu = mean_mem[c][1][47:0];
        r.mv = mean_mem[c][2][47:0];
        r.mw = mean_mem[c][3][47:0];
        r.ml = mean_mem[c][4][47:0];
        r.f0 = f[0][47:0];
        r.f1 = f[1][47:0];
        r.f2 = f[2][47:0];
        r.f3 = f[3][47:0];
        r.f4 = f[4][47:0];
        r.f5 = f[5][47:0];
        expected_avgs.push_back(r);
        if (it.last && step_n != 64'hFFFF_FFFF) step_n++;
    endtask

    // Driver: one item from the queue of pending cells, with random idle bursts.
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_acc) begin
                // hold the offered transfer
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cells.size() > 0) begin
                t_cell_state it;
                it = pending_cells.pop_front();
                s_axis_tdata <= {4'd0, it.pl, it.pw, it.pv, it.pu, it.p0, it.cidx};
                s_axis_tlast <= it.last;
                s_axis_tvalid <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    src_gap <= $urandom_range(1, 3);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready with random stall bursts and one long counted stall.
    int sink_gap = 0;
    always @(negedge i_clk) begin
        if (hold_sink && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 5) == 0)
                sink_gap <= $urandom_range(1, 3);
        end
    end

    // Input monitor: every accepted transfer goes to the predictor.
    always @(posedge i_clk) begin
        in_acc = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_acc) begin
            t_cell_state it;
            it.cidx = s_axis_tdata[11:0];
            it.p0 = s_axis_tdata[59:12];
            it.pu = s_axis_tdata[107:60];
            it.pv = s_axis_tdata[155:108];
            it.pw = s_axis_tdata[203:156];
            it.pl = s_axis_tdata[251:204];
            it.last = s_axis_tlast;
            predict_cell(it);
            sent++;
        end
    end

    // Output monitor: compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_cell_avg got, want;
            got = m_axis_tdata[OUT_TDATA_W-1-4:0];
            if (expected_avgs.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end else begin
                want = expected_avgs.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic addr, logic [1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (addr == CFG_AVG_ON) begin
            avg_on = val[0];
            if (!val[0]) step_n = 0;
        end else begin
            dim_reg = val;
        end
    endtask

    task automatic wait_idle();
        while (pending_cells.size() > 0 || s_axis_tvalid || expected_avgs.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        logic [47:0] v;
        case ($urandom_range(0, 7))
            0: v = 48'h7FFF_FFFF_FFFF;
            1: v = 48'h8000_0000_0000;
            2: v = 48'(sx({$urandom} & 48'h1F_FFFF));
            3: v = 48'(-longint'($urandom_range(0, 32'h3F_FFFF)));
            default: v = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
        endcase
        return v;
    endfunction

    // Cells are drawn from a small pool so means accumulate over several steps.
    task automatic queue_step(int count, int pool);
        t_cell_state it;
        for (int k = 0; k < count; k++) begin
            it.cidx = (pool >= NCELLS) ? 12'($urandom) : 12'($urandom_range(0, pool - 1));
            it.last = (k == count - 1) || ($urandom_range(0, 30) == 0);
            it.p0 = rand48();
            it.pu = rand48();
            it.pv = rand48();
            it.pw = rand48();
            it.pl = rand48();
            pending_cells.push_back(it);
        end
    endtask

    task automatic queue_one(logic [11:0] c, logic l, logic [47:0] a, logic [47:0] u);
        t_cell_state it;
        it = '{c, l, a, u, ~u, u ^ 48'h5555_5555_5555, ~a};
        pending_cells.push_back(it);
    endtask

    initial begin
        foreach (mean_mem[i, j]) mean_mem[i][j] = 0;
        foreach (prod_mem[i, j]) prod_mem[i][j] = 0;
        step_n = 0;
        avg_on = 1;
        dim_reg = 3;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, cell bounds, ties in the rounding.
        queue_one(12'd0, 1'b0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        queue_one(12'd4095, 1'b0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        queue_one(12'd0, 1'b1, 48'h0, 48'h0);
        queue_one(12'd0, 1'b1, 48'h3, 48'h1_0000);
        queue_one(12'd4095, 1'b1, 48'hFFFF_FFFF_FFFF, 48'h0_8000);
        queue_one(12'd1, 1'b0, 48'h1, 48'hFFFF_FFFF_FFFF);
        wait_idle();

        // Each dimension, including zero, with a short run in each.
        for (int d = 0; d < 4; d++) begin
            write_reg(CFG_DIM, 2'(d));
            queue_step(20, 8);
            wait_idle();
        end

        // Averaging off: items do nothing, count returns to zero.
        write_reg(CFG_AVG_ON, 2'd0);
        queue_step(10, 8);
        wait_idle();
        write_reg(CFG_AVG_ON, 2'd1);
        write_reg(CFG_DIM, 2'd3);

        // Long receiver stall while the sender keeps offering.
        hold_sink = 1;
        queue_step(150, 64);
        wait (hold_cnt == HOLD_CYCLES);
        hold_sink = 0;
        wait_idle();

        // Random phases over all settings.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_DIM, 2'($urandom_range(0, 3)));
            if (ph == 5) write_reg(CFG_AVG_ON, 2'd0);
            if (ph == 6) write_reg(CFG_AVG_ON, 2'd1);
            if (ph == 7) quiet_tail = 1;
            queue_step(140, (ph % 3 == 0) ? NCELLS : 32);
            wait_idle();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
